// ----- src/mbs_pkg.sv -----
// ---------------------------------------------------------------------------
// mbs_pkg - shared types and constants of the multipart boundary splitter
// Character codes, result kinds, register indexes, sequencer segment codes
// and the emission plan that the line tracker hands to the sequencer.
// ---------------------------------------------------------------------------
package mbs_pkg;

    // boundary storage
    localparam int             NUM_WORDS    = 6;
    localparam int             WORD_BITS    = 64;
    localparam logic [5:0]     MAX_BOUNDARY = 6'd48;
    localparam logic [5:0]     NUM_BCHARS   = 6'd48;
    localparam logic [3:0]     MAX_CR_RUN   = 4'd12;

    localparam logic [5:0]           BOUNDARY_RESET_LEN   = 6'd2;
    localparam logic [WORD_BITS-1:0] BOUNDARY_RESET_WORD0 = 64'd11565;

    // characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [1:0] CLOSE_DASHES = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_PART    = 2'd1;
    localparam logic [1:0] KIND_FINAL   = 2'd2;
    localparam logic [1:0] KIND_NOBOUND = 2'd3;
    localparam logic [1:0] FOUND_NONE   = 2'd0;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 3;
    localparam logic [2:0] REG_LEN        = 3'd0;
    localparam logic [2:0] REG_WORD_FIRST = 3'd1;
    localparam logic [2:0] REG_WORD_LAST  = 3'd6;

    // emission segments, in output order
    localparam int         NUM_SEG   = 14;
    localparam logic [3:0] SEG_R1CR  = 4'd0;
    localparam logic [3:0] SEG_R1LF  = 4'd1;
    localparam logic [3:0] SEG_R1CH  = 4'd2;
    localparam logic [3:0] SEG_R1DS  = 4'd3;
    localparam logic [3:0] SEG_CRS1  = 4'd4;
    localparam logic [3:0] SEG_BYTE  = 4'd5;
    localparam logic [3:0] SEG_OVF   = 4'd6;
    localparam logic [3:0] SEG_R2CR  = 4'd7;
    localparam logic [3:0] SEG_R2LF  = 4'd8;
    localparam logic [3:0] SEG_R2CH  = 4'd9;
    localparam logic [3:0] SEG_R2DS  = 4'd10;
    localparam logic [3:0] SEG_CRS2  = 4'd11;
    localparam logic [3:0] SEG_K3    = 4'd12;
    localparam logic [3:0] SEG_FOUND = 4'd13;

    typedef struct packed {
        logic       r1_cr;
        logic       r1_lf;
        logic [5:0] r1_m;
        logic [1:0] r1_d;
        logic [3:0] c1;
        logic       byte_en;
        logic       ovf_en;
        logic       r2_cr;
        logic       r2_lf;
        logic [5:0] r2_m;
        logic [1:0] r2_d;
        logic [3:0] c2;
        logic       k3;
        logic [1:0] found;
        logic [7:0] data_byte;
    } plan_t;

endpackage

// ----- src/multipart_boundary_splitter.sv -----
// ---------------------------------------------------------------------------
// multipart_boundary_splitter - multipart body boundary detector
// Splits a multipart body stream on a configured boundary line, replaying
// bytes that prove to be data and marking part and final boundaries.
//
//   channel  | dir | tdata            | tuser                      | tlast
//   ---------+-----+------------------+----------------------------+---------
//   s_axis   | in  | in_byte          | -                          | body_end
//   m_axis   | out | out_byte         | out_kind, cr_overflow      | last
//   cfg      | in  | 0 len, 1..6 boundary words, one write per cycle
//
// A byte is taken while the sequencer is idle; the result words it releases
// then leave one a cycle through the output register while the output is not
// stalled. The replay sequencer and its shared character fetch set that pace.
// A stalled output holds the sequencer, and s_tready stays low while the
// sequencer has words left. Reset clears the line state and loads
// the boundary "--".
// ---------------------------------------------------------------------------
module multipart_boundary_splitter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // in_byte
    input  logic                               s_tlast,   // body_end
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // out_byte
    output logic [2:0]                         m_tuser,   // [1:0] out_kind, [2] cr_overflow
    output logic                               m_tlast,   // last
    input  logic                               cfg_we,
    input  logic [mbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbs_pkg::WORD_BITS-1:0]      cfg_data
);

    logic [5:0]                  len_reg;
    logic [mbs_pkg::WORD_BITS-1:0] bword_reg [mbs_pkg::NUM_WORDS];
    logic [mbs_pkg::NUM_WORDS*mbs_pkg::WORD_BITS-1:0] boundary_flat;

    logic           accept;
    logic           busy;
    logic [5:0]     match_idx;
    logic [5:0]     seq_idx;
    logic [5:0]     char_idx;
    logic [7:0]     char_byte;
    mbs_pkg::plan_t plan;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= mbs_pkg::BOUNDARY_RESET_LEN;
            for (int k = 0; k < mbs_pkg::NUM_WORDS; k++)
                bword_reg[k] <= (k == 0) ? mbs_pkg::BOUNDARY_RESET_WORD0 : '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mbs_pkg::REG_LEN)
                len_reg <= cfg_data[5:0];
            else if (cfg_index >= mbs_pkg::REG_WORD_FIRST &&
                     cfg_index <= mbs_pkg::REG_WORD_LAST)
                bword_reg[cfg_index - mbs_pkg::REG_WORD_FIRST] <= cfg_data;
        end
    end

    for (genvar g = 0; g < mbs_pkg::NUM_WORDS; g++)
    begin : g_flat
        assign boundary_flat[g*mbs_pkg::WORD_BITS +: mbs_pkg::WORD_BITS] = bword_reg[g];
    end

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    // the sequencer owns the fetch unit while replaying
    assign char_idx = busy ? seq_idx : match_idx;

    mbs_char_unit u_char (
        .boundary_flat (boundary_flat),
        .idx           (char_idx),
        .char_byte     (char_byte)
    );

    mbs_line_fsm u_line (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (s_tdata),
        .body_end     (s_tlast),
        .boundary_len (len_reg),
        .char_byte    (char_byte),
        .match_idx    (match_idx),
        .plan         (plan)
    );

    mbs_emit_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .plan      (plan),
        .char_byte (char_byte),
        .char_idx  (seq_idx),
        .busy      (busy),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- src/mbs_char_unit.sv -----
// ---------------------------------------------------------------------------
// mbs_char_unit - boundary character fetch
// Picks one boundary character by index; shared by the line matcher and the
// replay sequencer.
// ---------------------------------------------------------------------------
module mbs_char_unit (
    input  logic [mbs_pkg::NUM_WORDS*mbs_pkg::WORD_BITS-1:0] boundary_flat,
    input  logic [5:0]                                       idx,
    output logic [7:0]                                       char_byte
);

    logic [8:0] bit_pos;

    assign bit_pos   = {idx, 3'b000};
    assign char_byte = (idx < mbs_pkg::NUM_BCHARS) ? boundary_flat[bit_pos +: 8] : 8'd0;

endmodule

// ----- src/mbs_line_fsm.sv -----
// ---------------------------------------------------------------------------
// mbs_line_fsm - line state tracker
// Holds the per-line match state and, for each accepted byte, works out the
// next state and the plan of words that the byte releases.
// ---------------------------------------------------------------------------
module mbs_line_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic                  body_end,
    input  logic [5:0]            boundary_len,
    input  logic [7:0]            char_byte,
    output logic [5:0]            match_idx,
    output mbs_pkg::plan_t        plan
);

    logic       lmb_reg, lmb_next;
    logic [3:0] held_reg, held_next;
    logic       pend_reg, pend_next;
    logic       seen_reg, seen_next;
    logic [5:0] m_reg, m_next;
    logic [1:0] d_reg, d_next;
    logic       pp_reg, pp_next;

    logic [5:0]     eff_len;
    logic [1:0]     found;
    mbs_pkg::plan_t plan_next;

    always_comb
    begin
        if (boundary_len > mbs_pkg::MAX_BOUNDARY)
            eff_len = mbs_pkg::MAX_BOUNDARY;
        else if (boundary_len == 6'd0)
            eff_len = 6'd1;
        else
            eff_len = boundary_len;
    end

    assign match_idx = m_reg;

    always_comb
    begin
        lmb_next  = lmb_reg;
        held_next = held_reg;
        pend_next = pend_reg;
        seen_next = seen_reg;
        m_next    = m_reg;
        d_next    = d_reg;
        pp_next   = pp_reg;
        found     = mbs_pkg::FOUND_NONE;
        plan_next = '0;
        plan_next.data_byte = in_byte;

        if (lmb_reg)
        begin
            if (in_byte == mbs_pkg::CH_CR)
            begin
                if (held_reg == 4'd0)
                    held_next = 4'd1;
                else
                begin
                    // second CR: the line is data, replay the held prefix
                    plan_next.r1_cr = pend_reg;
                    plan_next.r1_lf = seen_reg;
                    plan_next.r1_m  = m_reg;
                    plan_next.r1_d  = d_reg;
                    pend_next = 1'b0;
                    seen_next = 1'b0;
                    m_next    = 6'd0;
                    d_next    = 2'd0;
                    lmb_next  = 1'b0;
                    held_next = 4'd2;
                end
            end
            else if (in_byte == mbs_pkg::CH_LF)
            begin
                if (m_reg == eff_len && d_reg != 2'd1)
                    found = (d_reg == mbs_pkg::CLOSE_DASHES) ? mbs_pkg::KIND_FINAL
                                                             : mbs_pkg::KIND_PART;
                else
                begin
                    plan_next.r1_cr = pend_reg;
                    plan_next.r1_lf = seen_reg;
                    plan_next.r1_m  = m_reg;
                    plan_next.r1_d  = d_reg;
                    plan_next.c1    = (held_reg > 4'd1) ? held_reg - 4'd1 : 4'd0;
                    pend_next = (held_reg != 4'd0);
                    seen_next = 1'b1;
                    held_next = 4'd0;
                    m_next    = 6'd0;
                    d_next    = 2'd0;
                    lmb_next  = 1'b1;
                end
            end
            else if (held_reg == 4'd0 && in_byte == mbs_pkg::CH_DASH &&
                     m_reg == eff_len && d_reg < mbs_pkg::CLOSE_DASHES)
                d_next = d_reg + 2'd1;
            else if (held_reg == 4'd0 && d_reg == 2'd0 && m_reg < eff_len &&
                     in_byte == char_byte)
                m_next = m_reg + 6'd1;
            else
            begin
                plan_next.r1_cr   = pend_reg;
                plan_next.r1_lf   = seen_reg;
                plan_next.r1_m    = m_reg;
                plan_next.r1_d    = d_reg;
                plan_next.c1      = held_reg;
                plan_next.byte_en = 1'b1;
                pend_next = 1'b0;
                seen_next = 1'b0;
                m_next    = 6'd0;
                d_next    = 2'd0;
                held_next = 4'd0;
                lmb_next  = 1'b0;
            end
        end
        else if (in_byte == mbs_pkg::CH_CR)
        begin
            // saturate the held run, pass further CRs straight on
            if (held_reg < mbs_pkg::MAX_CR_RUN)
                held_next = held_reg + 4'd1;
            else
                plan_next.ovf_en = 1'b1;
        end
        else if (in_byte == mbs_pkg::CH_LF)
        begin
            plan_next.c1 = (held_reg > 4'd1) ? held_reg - 4'd1 : 4'd0;
            pend_next = (held_reg != 4'd0);
            seen_next = 1'b1;
            held_next = 4'd0;
            m_next    = 6'd0;
            d_next    = 2'd0;
            lmb_next  = 1'b1;
        end
        else
        begin
            plan_next.c1      = held_reg;
            plan_next.byte_en = 1'b1;
            held_next = 4'd0;
        end

        if (found == mbs_pkg::FOUND_NONE && body_end)
        begin
            if (lmb_next && held_next < 4'd2 && m_next == eff_len &&
                d_next == mbs_pkg::CLOSE_DASHES)
                found = mbs_pkg::KIND_FINAL;
            else
            begin
                plan_next.r2_cr = pend_next;
                plan_next.r2_lf = seen_next;
                plan_next.r2_m  = m_next;
                plan_next.r2_d  = d_next;
                plan_next.c2    = held_next;
                plan_next.k3    = 1'b1;
            end
        end

        if (found != mbs_pkg::FOUND_NONE || body_end)
        begin
            m_next    = 6'd0;
            d_next    = 2'd0;
            held_next = 4'd0;
            pend_next = 1'b0;
            seen_next = 1'b0;
            lmb_next  = 1'b1;
            pp_next   = (found == mbs_pkg::KIND_PART) && !body_end;
        end
        plan_next.found = found;

        // drop data words while still in the preamble
        if (!pp_reg)
        begin
            plan_next.r1_cr   = 1'b0;
            plan_next.r1_lf   = 1'b0;
            plan_next.r1_m    = 6'd0;
            plan_next.r1_d    = 2'd0;
            plan_next.c1      = 4'd0;
            plan_next.byte_en = 1'b0;
            plan_next.ovf_en  = 1'b0;
            plan_next.r2_cr   = 1'b0;
            plan_next.r2_lf   = 1'b0;
            plan_next.r2_m    = 6'd0;
            plan_next.r2_d    = 2'd0;
            plan_next.c2      = 4'd0;
        end
    end

    assign plan = plan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmb_reg  <= 1'b1;
            held_reg <= 4'd0;
            pend_reg <= 1'b0;
            seen_reg <= 1'b0;
            m_reg    <= 6'd0;
            d_reg    <= 2'd0;
            pp_reg   <= 1'b0;
        end
        else if (accept)
        begin
            lmb_reg  <= lmb_next;
            held_reg <= held_next;
            pend_reg <= pend_next;
            seen_reg <= seen_next;
            m_reg    <= m_next;
            d_reg    <= d_next;
            pp_reg   <= pp_next;
        end
    end

endmodule

// ----- src/mbs_emit_seq.sv -----
// ---------------------------------------------------------------------------
// mbs_emit_seq - result word sequencer
// Walks the plan of one byte segment by segment, one result word a cycle
// while the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module mbs_emit_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  mbs_pkg::plan_t plan,
    input  logic [7:0]     char_byte,
    output logic [5:0]     char_idx,
    output logic           busy,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [7:0]     m_tdata,     // out_byte
    output logic [2:0]     m_tuser,     // [1:0] out_kind, [2] cr_overflow
    output logic           m_tlast
);

    mbs_pkg::plan_t               plan_reg;
    logic [mbs_pkg::NUM_SEG-1:0]  mask_reg, mask_next;
    logic [5:0]                   idx_reg;
    logic                         out_valid_reg;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic [1:0]                   out_kind_reg, out_kind_next;
    logic                         out_ovf_reg, out_ovf_next;
    logic                         out_last_reg;

    logic [3:0]                   seg;
    logic [mbs_pkg::NUM_SEG-1:0]  seg_bit;
    logic [5:0]                   seg_count;
    logic                         seg_done;
    logic                         advance;
    logic                         is_last;

    // lowest pending segment goes first
    always_comb
    begin
        seg = mbs_pkg::SEG_FOUND;
        for (int i = mbs_pkg::NUM_SEG - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                seg = 4'(i);
        end
    end

    assign seg_bit = mbs_pkg::NUM_SEG'(1) << seg;

    always_comb
    begin
        case (seg)
            mbs_pkg::SEG_R1CH: seg_count = plan_reg.r1_m;
            mbs_pkg::SEG_R1DS: seg_count = {4'd0, plan_reg.r1_d};
            mbs_pkg::SEG_CRS1: seg_count = {2'd0, plan_reg.c1};
            mbs_pkg::SEG_R2CH: seg_count = plan_reg.r2_m;
            mbs_pkg::SEG_R2DS: seg_count = {4'd0, plan_reg.r2_d};
            mbs_pkg::SEG_CRS2: seg_count = {2'd0, plan_reg.c2};
            default:           seg_count = 6'd1;
        endcase
    end

    assign seg_done = (idx_reg + 6'd1) == seg_count;
    assign is_last  = seg_done && ((mask_reg & ~seg_bit) == '0);
    assign busy     = (mask_reg != '0);
    assign advance  = busy && (!out_valid_reg || m_tready);
    assign char_idx = idx_reg;

    always_comb
    begin
        out_kind_next = mbs_pkg::KIND_DATA;
        out_ovf_next  = 1'b0;
        case (seg)
            mbs_pkg::SEG_R1CR,
            mbs_pkg::SEG_CRS1,
            mbs_pkg::SEG_R2CR,
            mbs_pkg::SEG_CRS2:  out_byte_next = mbs_pkg::CH_CR;
            mbs_pkg::SEG_OVF:
            begin
                out_byte_next = mbs_pkg::CH_CR;
                out_ovf_next  = 1'b1;
            end
            mbs_pkg::SEG_R1LF,
            mbs_pkg::SEG_R2LF:  out_byte_next = mbs_pkg::CH_LF;
            mbs_pkg::SEG_R1CH,
            mbs_pkg::SEG_R2CH:  out_byte_next = char_byte;
            mbs_pkg::SEG_R1DS,
            mbs_pkg::SEG_R2DS:  out_byte_next = mbs_pkg::CH_DASH;
            mbs_pkg::SEG_BYTE:  out_byte_next = plan_reg.data_byte;
            mbs_pkg::SEG_K3:
            begin
                out_byte_next = 8'd0;
                out_kind_next = mbs_pkg::KIND_NOBOUND;
            end
            mbs_pkg::SEG_FOUND:
            begin
                out_byte_next = 8'd0;
                out_kind_next = plan_reg.found;
            end
            default:            out_byte_next = 8'd0;
        endcase
    end

    always_comb
    begin
        mask_next[mbs_pkg::SEG_R1CR]  = plan.r1_cr;
        mask_next[mbs_pkg::SEG_R1LF]  = plan.r1_lf;
        mask_next[mbs_pkg::SEG_R1CH]  = (plan.r1_m != 6'd0);
        mask_next[mbs_pkg::SEG_R1DS]  = (plan.r1_d != 2'd0);
        mask_next[mbs_pkg::SEG_CRS1]  = (plan.c1 != 4'd0);
        mask_next[mbs_pkg::SEG_BYTE]  = plan.byte_en;
        mask_next[mbs_pkg::SEG_OVF]   = plan.ovf_en;
        mask_next[mbs_pkg::SEG_R2CR]  = plan.r2_cr;
        mask_next[mbs_pkg::SEG_R2LF]  = plan.r2_lf;
        mask_next[mbs_pkg::SEG_R2CH]  = (plan.r2_m != 6'd0);
        mask_next[mbs_pkg::SEG_R2DS]  = (plan.r2_d != 2'd0);
        mask_next[mbs_pkg::SEG_CRS2]  = (plan.c2 != 4'd0);
        mask_next[mbs_pkg::SEG_K3]    = plan.k3;
        mask_next[mbs_pkg::SEG_FOUND] = (plan.found != mbs_pkg::FOUND_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mask_reg <= mask_next;
                idx_reg  <= 6'd0;
            end
            else if (advance)
            begin
                if (seg_done)
                begin
                    mask_reg <= mask_reg & ~seg_bit;
                    idx_reg  <= 6'd0;
                end
                else
                    idx_reg <= idx_reg + 6'd1;
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan;
        if (advance)
        begin
            out_byte_reg <= out_byte_next;
            out_kind_reg <= out_kind_next;
            out_ovf_reg  <= out_ovf_next;
            out_last_reg <= is_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_ovf_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule
